>>> hw/rtl/grid_ray_dda_caster_assert.svh
// Assertion macros used by the port checker of the ray caster.
`ifndef GRID_RAY_DDA_CASTER_ASSERT_SVH
`define GRID_RAY_DDA_CASTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define GDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Word types and fixed constants of the grid ray caster.
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam logic [23:0] MAX24      = 24'hFF_FFFF;
   localparam logic [11:0] ONE_Q11    = 12'd2048;
   localparam logic        MODE_WRITE = 1'b0;
   localparam logic        MODE_CAST  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [4:0]         cell_x;
      logic [4:0]         cell_y;
      logic               cell_wall;
      logic [15:0]        player_x;
      logic [15:0]        player_y;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
   } gdc_req_type;

   typedef struct packed {
      logic [4:0]  hit_cell_x;
      logic [4:0]  hit_cell_y;
      logic        hit_side;
      logic [23:0] perp_dist;
      logic [15:0] wall_frac;
      logic        no_hit;
   } gdc_rsp_type;

endpackage

>>> hw/rtl/gdc_ram.sv
// ----------------------------------------------------------------------------
// gdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/gdc_div.sv
// ----------------------------------------------------------------------------
// gdc_div
// Restoring divider, one quotient bit per cycle, 16-bit unsigned divisor.
// ----------------------------------------------------------------------------
module gdc_div
   import gdc_pkg::*;
#(
   parameter int DW = 38
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          div_start,
   input  logic [DW-1:0] dividend,
   input  logic [15:0]   divisor,
   output logic          div_done,
   output logic [DW-1:0] quotient
);

   localparam int CTW = $clog2(DW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic [16:0]   trial;
   logic [16:0]   diff;
   logic          ge;

   always_comb begin
      trial  = {rem_ff, acc_ff[DW-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (div_start) begin
         run_in = 1'b1;
         cnt_in = CTW'(DW);
         acc_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         acc_in = {acc_ff[DW-2:0], ge};
         rem_in = ge ? diff[15:0] : trial[15:0];
         cnt_in = cnt_ff - CTW'(1);
         if (cnt_ff == CTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done = done_ff;
   assign quotient = acc_ff;

endmodule

>>> hw/rtl/grid_ray_dda_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_caster
// DDA ray caster over a square one-bit wall map held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_data and raise start; the word is taken at an edge
//    where start is high and busy is low. mode MODE_WRITE sets one map cell
//    and gives no result; busy stays low.
//  - mode MODE_CAST walks the ray and returns one result word on rsp_data,
//    marked by rsp_valid for exactly one cycle. The receiver cannot stall;
//    the word must be taken in that cycle.
//  - Cast: the shared serial divider, DW bits wide (38 at the default map
//    size), works out in turn the two step lengths (a zero axis skips its
//    division); then the ray walks at most MAX_STEPS cells, one map RAM read
//    per walked cell; then the divider gives the distance and the wall
//    position, each by one division.
//  - Throughput: one cast at a time; busy stays high until the result.
//  - Reset: after reset the block sweeps the map to open, one cell per cycle,
//    MAP_SIZE * MAP_SIZE cells (1024 by default), with busy high.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster
   import gdc_pkg::*;
#(
   parameter int MAP_SIZE  = 32,
   parameter int MAX_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  gdc_req_type req_data,
   output logic        rsp_valid,
   output gdc_rsp_type rsp_data
);

   localparam int CW    = $clog2(MAP_SIZE);
   localparam int SW    = CW + 2;
   localparam int AW    = $clog2(MAP_SIZE * MAP_SIZE);
   localparam int DEPTH = MAP_SIZE * MAP_SIZE;
   localparam int NW    = (CW > 5 ? CW : 5) + 11;
   localparam int DW    = NW + 22;
   localparam int CNW   = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_DIVX  = 4'd3;
   localparam logic [3:0] S_DIVY  = 4'd4;
   localparam logic [3:0] S_FIRST = 4'd5;
   localparam logic [3:0] S_STEP  = 4'd6;
   localparam logic [3:0] S_TEST  = 4'd7;
   localparam logic [3:0] S_NUM   = 4'd8;
   localparam logic [3:0] S_QMUL  = 4'd9;
   localparam logic [3:0] S_PERP  = 4'd10;
   localparam logic [3:0] S_WALL  = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [15:0]          px_ff, px_in, py_ff, py_in;
   logic [15:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic signed [SW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [23:0]          ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [23:0]          sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic                 side_ff, side_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [15:0]          aa_ff, aa_in, ao_ff, ao_in, opos_ff, opos_in;
   logic                 oneg_ff, oneg_in;
   logic [DW-1:0]        q_ff, q_in;
   logic [23:0]          perp_ff, perp_in;
   logic                 div_run_ff, div_run_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   gdc_rsp_type          rsp_ff, rsp_in;

   // map RAM ports
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic                 ram_wdata, ram_rdata;

   // divider ports
   logic                 div_start, div_done;
   logic [DW-1:0]        div_dividend, div_quotient;
   logic [15:0]          div_divisor;
   logic [23:0]          div_sat;

   // helpers
   logic [15:0]          req_ax, req_ay;
   logic                 req_out;
   logic [11:0]          nx, ny;
   logic [35:0]          fx_prod, fy_prod;
   logic [24:0]          sum_x, sum_y;
   logic                 step_x, out_map;
   logic [31:0]          num_wide, mx_w, my_w;
   logic [NW+15:0]       qprod;
   logic [15:0]          wall_base, wall;
   gdc_rsp_type          miss;

   gdc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   gdc_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .div_done  (div_done),
      .quotient  (div_quotient)
   );

   assign div_sat = (|div_quotient[DW-1:24]) ? MAX24 : div_quotient[23:0];

   always_comb begin
      // defaults: hold every register but the result strobe
      state_in     = state_ff;
      clr_in       = clr_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      ddx_in       = ddx_ff;
      ddy_in       = ddy_ff;
      sdx_in       = sdx_ff;
      sdy_in       = sdy_ff;
      side_in      = side_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      aa_in        = aa_ff;
      ao_in        = ao_ff;
      opos_in      = opos_ff;
      oneg_in      = oneg_ff;
      q_in         = q_ff;
      perp_in      = perp_ff;
      div_run_in   = div_run_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = 1'b0;
      ram_raddr    = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      miss         = '0;
      miss.no_hit  = 1'b1;

      req_ax  = req_data.ray_dir_x[15] ? 16'(-req_data.ray_dir_x) : req_data.ray_dir_x;
      req_ay  = req_data.ray_dir_y[15] ? 16'(-req_data.ray_dir_y) : req_data.ray_dir_y;
      req_out = (32'(req_data.player_x[15:11]) >= 32'(MAP_SIZE))
             || (32'(req_data.player_y[15:11]) >= 32'(MAP_SIZE));

      // distance to the first boundary, Q1.11 in 12 bits
      nx = dx_ff[15] ? {1'b0, px_ff[10:0]} : ONE_Q11 - {1'b0, px_ff[10:0]};
      ny = dy_ff[15] ? {1'b0, py_ff[10:0]} : ONE_Q11 - {1'b0, py_ff[10:0]};
      fx_prod = 36'(nx) * 36'(ddx_ff);
      fy_prod = 36'(ny) * 36'(ddy_ff);

      sum_x  = {1'b0, sdx_ff} + {1'b0, ddx_ff};
      sum_y  = {1'b0, sdy_ff} + {1'b0, ddy_ff};
      step_x = (ax_ff != '0) && ((ay_ff == '0) || (sdx_ff < sdy_ff));

      out_map = mx_ff[SW-1] || my_ff[SW-1]
             || (mx_ff[SW-2:0] >= (SW-1)'(MAP_SIZE))
             || (my_ff[SW-2:0] >= (SW-1)'(MAP_SIZE));

      mx_w = 32'(mx_ff[SW-2:0]);
      my_w = 32'(my_ff[SW-2:0]);
      if (!side_ff) begin
         num_wide = dx_ff[15] ? 32'(px_ff) - ((mx_w + 32'd1) << 11)
                              : (mx_w << 11) - 32'(px_ff);
      end else begin
         num_wide = dy_ff[15] ? 32'(py_ff) - ((my_w + 32'd1) << 11)
                              : (my_w << 11) - 32'(py_ff);
      end

      qprod     = (NW+16)'(num_ff) * (NW+16)'(ao_ff);
      wall_base = {opos_ff[10:0], 5'b0};
      wall      = oneg_ff ? wall_base - div_quotient[15:0]
                          : wall_base + div_quotient[15:0];

      case (state_ff)
         S_CLEAR: begin
            // sweep the map to open
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_data.mode == MODE_WRITE) begin
                  // drop writes outside the map
                  ram_we    = (32'(req_data.cell_x) < 32'(MAP_SIZE))
                           && (32'(req_data.cell_y) < 32'(MAP_SIZE));
                  ram_waddr = AW'(32'(req_data.cell_x) * 32'(MAP_SIZE)
                                  + 32'(req_data.cell_y));
                  ram_wdata = req_data.cell_wall;
               end else begin
                  px_in    = req_data.player_x;
                  py_in    = req_data.player_y;
                  dx_in    = req_data.ray_dir_x;
                  dy_in    = req_data.ray_dir_y;
                  ax_in    = req_ax;
                  ay_in    = req_ay;
                  mx_in    = SW'(req_data.player_x[15:11]);
                  my_in    = SW'(req_data.player_y[15:11]);
                  side_in  = req_out || (req_ax == '0 && req_ay == '0);
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // side_ff carries the early miss flag here
            if (side_ff) begin
               rsp_in       = miss;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            div_dividend = DW'(64'h4000_0000);
            div_divisor  = ax_ff;
            if (ax_ff == '0) begin
               ddx_in   = MAX24;
               state_in = S_DIVY;
            end else if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               ddx_in     = div_sat;
               div_run_in = 1'b0;
               state_in   = S_DIVY;
            end
         end
         S_DIVY: begin
            div_dividend = DW'(64'h4000_0000);
            div_divisor  = ay_ff;
            if (ay_ff == '0) begin
               ddy_in   = MAX24;
               state_in = S_FIRST;
            end else if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               ddy_in     = div_sat;
               div_run_in = 1'b0;
               state_in   = S_FIRST;
            end
         end
         S_FIRST: begin
            sdx_in   = fx_prod[35] ? MAX24 : fx_prod[34:11];
            sdy_in   = fy_prod[35] ? MAX24 : fy_prod[34:11];
            cnt_in   = '0;
            state_in = S_STEP;
         end
         S_STEP: begin
            // advance one cell along the nearer boundary
            if (step_x) begin
               sdx_in  = sum_x[24] ? MAX24 : sum_x[23:0];
               mx_in   = dx_ff[15] ? mx_ff - SW'(1) : mx_ff + SW'(1);
               side_in = 1'b0;
            end else begin
               sdy_in  = sum_y[24] ? MAX24 : sum_y[23:0];
               my_in   = dy_ff[15] ? my_ff - SW'(1) : my_ff + SW'(1);
               side_in = 1'b1;
            end
            ram_raddr = AW'(32'(mx_in[CW-1:0]) * 32'(MAP_SIZE) + 32'(my_in[CW-1:0]));
            state_in  = S_TEST;
         end
         S_TEST: begin
            if (out_map) begin
               rsp_in       = miss;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (ram_rdata) begin
               state_in = S_NUM;
            end else if (cnt_ff == CNW'(MAX_STEPS - 1)) begin
               rsp_in       = miss;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cnt_in   = cnt_ff + CNW'(1);
               state_in = S_STEP;
            end
         end
         S_NUM: begin
            num_in   = num_wide[NW-1:0];
            aa_in    = side_ff ? ay_ff : ax_ff;
            ao_in    = side_ff ? ax_ff : ay_ff;
            oneg_in  = side_ff ? dx_ff[15] : dy_ff[15];
            opos_in  = side_ff ? px_ff : py_ff;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            q_in     = DW'({qprod, 5'b0});
            state_in = S_PERP;
         end
         S_PERP: begin
            div_dividend = DW'({num_ff, 19'b0});
            div_divisor  = aa_ff;
            if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               perp_in    = div_sat;
               div_run_in = 1'b0;
               state_in   = S_WALL;
            end
         end
         S_WALL: begin
            // round the offset up on a negative other axis, so the wall position rounds down
            div_dividend = oneg_ff ? q_ff + DW'(aa_ff - 16'd1) : q_ff;
            div_divisor  = aa_ff;
            if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               div_run_in        = 1'b0;
               rsp_in.hit_cell_x = 5'(mx_ff[SW-2:0]);
               rsp_in.hit_cell_y = 5'(my_ff[SW-2:0]);
               rsp_in.hit_side   = side_ff;
               rsp_in.perp_dist  = perp_ff;
               rsp_in.wall_frac  = wall;
               rsp_in.no_hit     = 1'b0;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      ddx_ff  <= ddx_in;
      ddy_ff  <= ddy_in;
      sdx_ff  <= sdx_in;
      sdy_ff  <= sdy_in;
      side_ff <= side_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      aa_ff   <= aa_in;
      ao_ff   <= ao_in;
      opos_ff <= opos_in;
      oneg_ff <= oneg_in;
      q_ff    <= q_in;
      perp_ff <= perp_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/gdc_checker.sv
// ----------------------------------------------------------------------------
// gdc_checker
// Port-level checks of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_ray_dda_caster_assert.svh"

module gdc_checker
   import gdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input gdc_req_type req_data,
   input logic        rsp_valid,
   input gdc_rsp_type rsp_data
);

   `GDC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && rsp_data.no_hit, (rsp_data.hit_cell_x == '0) && (rsp_data.hit_cell_y == '0) && !rsp_data.hit_side && (rsp_data.perp_dist == '0) && (rsp_data.wall_frac == '0), "miss word carries nonzero fields")
   `GDC_ASSERT_NEXT(a_cast_busy, clock, reset, start && !busy && (req_data.mode == MODE_CAST), busy, "cast word taken but block not busy")
   `GDC_ASSERT_NEXT(a_write_quiet, clock, reset, start && !busy && (req_data.mode == MODE_WRITE), !rsp_valid, "write word produced a result")
   `GDC_ASSERT_NOW(a_rsp_ready, clock, reset, rsp_valid, !busy, "result shown while still busy")

endmodule

bind grid_ray_dda_caster gdc_checker u_gdc_checker (.*);

>>> verif/grid_ray_dda_caster_checker.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_caster_checker
// Watches the request and result channels of the ray caster, keeps its own
// copy of the wall map, predicts each cast result and compares the whole word.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster_checker
   import gdc_pkg::*;
#(
   parameter int MAP_SIZE  = 32,
   parameter int MAX_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  gdc_req_type req_data,
   input  logic        rsp_valid,
   input  gdc_rsp_type rsp_data,
   output int          fail_count,
   output int          pending_casts
);

   logic        cell_map [MAP_SIZE*MAP_SIZE];
   gdc_rsp_type cast_queue [$];

   function automatic logic [23:0] clip24(input logic [63:0] v);
      return (v > 64'(MAX24)) ? MAX24 : v[23:0];
   endfunction

   function automatic gdc_rsp_type trace_ray(input gdc_req_type w);
      gdc_rsp_type r;
      int          dx, dy, mx, my, odir, n;
      logic [31:0] ax, ay, aa, ao, opos, num, fx, fy;
      logic [23:0] ddx, ddy, sdx, sdy;
      logic [63:0] q, wpos;
      logic        side, hit;
      r = '0;
      r.no_hit = 1'b1;
      side = 1'b0;
      hit = 1'b0;
      dx = w.ray_dir_x;
      dy = w.ray_dir_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      mx = w.player_x >> 11;
      my = w.player_y >> 11;
      if ((ax == 0 && ay == 0) || mx >= MAP_SIZE || my >= MAP_SIZE) return r;
      ddx = (ax != 0) ? clip24((64'd1 << 30) / ax) : MAX24;
      ddy = (ay != 0) ? clip24((64'd1 << 30) / ay) : MAX24;
      fx = w.player_x & 32'h7FF;
      fy = w.player_y & 32'h7FF;
      if (dx >= 0) fx = 32'd2048 - fx;
      if (dy >= 0) fy = 32'd2048 - fy;
      sdx = clip24((64'(fx) * ddx) >> 11);
      sdy = clip24((64'(fy) * ddy) >> 11);
      for (n = 0; n < MAX_STEPS; n++) begin
         if (ax != 0 && (ay == 0 || sdx < sdy)) begin
            sdx = clip24(64'(sdx) + ddx);
            mx += (dx < 0) ? -1 : 1;
            side = 1'b0;
         end else begin
            sdy = clip24(64'(sdy) + ddy);
            my += (dy < 0) ? -1 : 1;
            side = 1'b1;
         end
         if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) return r;
         if (cell_map[mx*MAP_SIZE + my]) begin
            hit = 1'b1;
            break;
         end
      end
      if (!hit) return r;
      if (!side) begin
         num = (dx < 0) ? w.player_x - (mx + 1) * 2048 : mx * 2048 - w.player_x;
         aa = ax; ao = ay; odir = dy; opos = w.player_y;
      end else begin
         num = (dy < 0) ? w.player_y - (my + 1) * 2048 : my * 2048 - w.player_y;
         aa = ay; ao = ax; odir = dx; opos = w.player_x;
      end
      q = 64'(num) * ao * 32;
      if (odir < 0) wpos = (64'(opos) << 5) - (q + aa - 1) / aa;
      else wpos = (64'(opos) << 5) + q / aa;
      r.hit_cell_x = mx[4:0];
      r.hit_cell_y = my[4:0];
      r.hit_side   = side;
      r.perp_dist  = clip24((64'(num) << 19) / aa);
      r.wall_frac  = wpos[15:0];
      r.no_hit     = 1'b0;
      return r;
   endfunction

   assign pending_casts = cast_queue.size();

   always @(posedge clock) begin
      gdc_rsp_type want;
      if (reset) begin
         foreach (cell_map[k]) cell_map[k] = 1'b0;
         cast_queue.delete();
         fail_count <= 0;
      end else begin
         // compare the result first; a write accepted at the same edge comes later
         if (rsp_valid) begin
            if (cast_queue.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = cast_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: result mismatch expected x=%0d y=%0d side=%0d dist=%h frac=%h nohit=%0d actual x=%0d y=%0d side=%0d dist=%h frac=%h nohit=%0d",
                     $time, want.hit_cell_x, want.hit_cell_y, want.hit_side, want.perp_dist,
                     want.wall_frac, want.no_hit, rsp_data.hit_cell_x, rsp_data.hit_cell_y,
                     rsp_data.hit_side, rsp_data.perp_dist, rsp_data.wall_frac, rsp_data.no_hit);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.mode == MODE_WRITE) begin
               if (req_data.cell_x < MAP_SIZE && req_data.cell_y < MAP_SIZE)
                  cell_map[req_data.cell_x*MAP_SIZE + req_data.cell_y] = req_data.cell_wall;
            end else begin
               cast_queue.push_back(trace_ray(req_data));
            end
         end
      end
   end

endmodule

>>> verif/tb_grid_ray_dda_caster.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_dda_caster
// Drives map writes and ray casts into the caster: directed corners first,
// then random maze layouts with random casts under varying sender idling.
// The checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_grid_ray_dda_caster;
   import gdc_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   gdc_req_type req_data;
   logic        rsp_valid;
   gdc_rsp_type rsp_data;
   int          fail_count;
   int          pending_casts;
   int          idle_pct;

   grid_ray_dda_caster i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   grid_ray_dda_caster_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_casts(pending_casts)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: the time for about 1150 words plus the map sweep,
   // taken several times over.
   initial begin
      #(12 * 3000000);
      $display("grid_ray_dda_caster test failed");
      $finish;
   end

   // Present one word and hold start until busy is low (not taken if busy at first);
   // start stays high so the next word can follow at once; the caller then drops it.
   task automatic send_word(input gdc_req_type w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_cell(input int x, input int y, input logic wall);
      gdc_req_type w;
      w           = gdc_req_type'(76'({$urandom, $urandom, $urandom}));
      w.mode      = MODE_WRITE;
      w.cell_x    = 5'(x);
      w.cell_y    = 5'(y);
      w.cell_wall = wall;
      send_word(w);
   endtask

   task automatic shoot_ray(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] dx, input logic [15:0] dy);
      gdc_req_type w;
      w           = gdc_req_type'(76'({$urandom, $urandom, $urandom}));
      w.mode      = MODE_CAST;
      w.player_x  = px;
      w.player_y  = py;
      w.ray_dir_x = dx;
      w.ray_dir_y = dy;
      send_word(w);
   endtask

   // Random unit-ish direction; mostly in range, sometimes any bit pattern.
   function automatic logic [15:0] pick_dir();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 16'($urandom);
      if (sel == 1) return 16'(0);
      if (sel == 2) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // Any 16-bit position; with the default map every position lies inside it.
   function automatic logic [15:0] pick_pos();
      return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16'hFFFF));
   endfunction

   task automatic build_room();
      int k;
      for (k = 0; k < 12; k++)
         write_cell($urandom_range(31), $urandom_range(31), $urandom_range(3) != 0);
   endtask

   task automatic run_phase(input int pct, input int words);
      int n;
      idle_pct = pct;
      n = 0;
      while (n < words) begin
         if ($urandom_range(4) == 0) begin
            build_room();
            n += 12;
         end else begin
            shoot_ray(pick_pos(), pick_pos(), pick_dir(), pick_dir());
            n++;
         end
      end
   endtask

   initial begin
      int k;
      start    <= 1'b0;
      req_data <= '0;
      idle_pct  = 0;
      reset    <= 1'b1;
      repeat (5) @(posedge clock);
      reset    <= 1'b0;
      @(posedge clock);

      // directed: empty map leaves through the border, zero directions, starts
      // on the map edge, start cell a wall, then dotted walls at index 20
      shoot_ray(16'h0400, 16'h0400, 16'sd16384, 16'sd0);
      shoot_ray(16'h0400, 16'h0400, 16'sd0, 16'sd0);
      shoot_ray(16'hFFFF, 16'h0000, -16'sd16384, 16'sd0);
      shoot_ray(16'h0000, 16'hFFFF, 16'sd0, 16'sd16384);
      write_cell(0, 0, 1'b1);
      write_cell(31, 31, 1'b1);
      shoot_ray(16'h0000, 16'h0000, 16'sd11585, 16'sd11585);
      shoot_ray(16'hF800, 16'hF800, -16'sd11585, -16'sd11585);
      for (k = 0; k < 32; k += 4) begin
         write_cell(k, 20, 1'b1);
         write_cell(20, k, 1'b1);
      end
      shoot_ray(16'h2000, 16'h2000, 16'sd16384, 16'sd1);
      shoot_ray(16'h2000, 16'h2000, -16'sd1, 16'sd16384);
      shoot_ray(16'h2000, 16'h2000, 16'h8000, 16'h7FFF);
      shoot_ray(16'h2000, 16'h2000, 16'sd3, 16'sd2);
      shoot_ray(16'h27FF, 16'h2000, 16'sd11585, -16'sd11585);

      // random: sender idles lightly, then heavily, then not at all
      run_phase(26, 373);
      run_phase(48, 373);
      run_phase(0, 373);
      start <= 1'b0;

      k = 0;
      while (pending_casts != 0 && k < 100000) begin
         @(posedge clock);
         k++;
      end
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_casts == 0) begin
         $display("grid_ray_dda_caster test passed");
      end else begin
         $display("grid_ray_dda_caster test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/gdc_pkg.sv
hw/rtl/gdc_ram.sv
hw/rtl/gdc_div.sv
hw/rtl/grid_ray_dda_caster.sv
hw/rtl/gdc_checker.sv
verif/grid_ray_dda_caster_checker.sv
verif/tb_grid_ray_dda_caster.sv
